// File: rtl/core/tvbb_pkg.sv
// Package for the transformed-vertex bounding box.
// Holds coordinate types, reset constants and the fixed-point affine row.
// No dependencies.
`timescale 1ns / 1ps

package tvbb_pkg;

  localparam int unsigned FRAC_BITS  = 12;
  localparam int unsigned VERT_W     = 16;
  localparam int unsigned COORD_W    = 21;
  localparam int unsigned ROW_W      = 64;
  localparam int unsigned NUM_ROWS   = 3;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned IN_DATA_W  = 48;
  localparam int unsigned OUT_DATA_W = 128;

  typedef logic signed [VERT_W-1:0]  vert_t;
  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [ROW_W-1:0]          row_t;

  localparam coord_t CORNER_MAX = 21'sh0F_FFFF;
  localparam coord_t CORNER_MIN = 21'sh10_0000;

  // Identity transform, zero translation.
  localparam row_t ROW_X_RESET = 64'h0000_0000_0000_1000;
  localparam row_t ROW_Y_RESET = 64'h0000_0000_1000_0000;
  localparam row_t ROW_Z_RESET = 64'h0000_1000_0000_0000;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_ROW_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_Z = 2'd2;

  // One output coordinate: Q4.12 dot product, floor shift, integer translation.
  function automatic coord_t apply_row(row_t row, vert_t vx, vert_t vy, vert_t vz);
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic signed [33:0] s;
    logic signed [21:0] q;
    logic signed [22:0] r;
    px = $signed(row[15:0]) * vx;
    py = $signed(row[31:16]) * vy;
    pz = $signed(row[47:32]) * vz;
    s  = {{2{px[31]}}, px} + {{2{py[31]}}, py} + {{2{pz[31]}}, pz};
    q  = s[33:FRAC_BITS];
    r  = {q[21], q} + {{7{row[63]}}, row[63:48]};
    return r[COORD_W-1:0];
  endfunction

endpackage

// File: rtl/core/transformed_vertex_bounding_box.sv
// Transformed-vertex bounding box: affine transform of each vertex and a
// running axis-aligned box over the results. Depends on tvbb_pkg.
`timescale 1ns / 1ps

//  channel   | direction | fields (low bit first)
//  s_axis    | in        | tdata: vertex_x, vertex_y, vertex_z; tuser: first_vertex
//  m_axis    | out       | tdata: min_x, min_y, min_z, max_x, max_y, max_z, 2 pad bits
//  cfg       | in        | write of row_x / row_y / row_z coefficients by index
//
// One vertex per cycle sustained while m_axis_tready is high; each vertex passes
// the input register, then the box corners, which are themselves the result
// register, updated by one pass of multiply, add, shift and compare.
// A stalled result holds the input register; tready drops only in reset or when
// both stages are full and m_axis_tready is low. rst clears the rows to identity
// and the corners to their extreme values.

module transformed_vertex_bounding_box (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  // vertex_x [15:0], vertex_y [31:16], vertex_z [47:32]
  input  logic [tvbb_pkg::IN_DATA_W-1:0]         s_axis_tdata,
  // first_vertex [0]
  input  logic                                   s_axis_tuser,
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  // min_x [20:0], min_y [41:21], min_z [62:42],
  // max_x [83:63], max_y [104:84], max_z [125:105], zeros [127:126]
  output logic [tvbb_pkg::OUT_DATA_W-1:0]        m_axis_tdata,
  input  logic                                   cfg_we,
  input  logic [tvbb_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [tvbb_pkg::ROW_W-1:0]             cfg_data
);

  tvbb_pkg::row_t   rows [tvbb_pkg::NUM_ROWS];

  logic             in_valid;
  logic             in_first;
  tvbb_pkg::vert_t  in_x;
  tvbb_pkg::vert_t  in_y;
  tvbb_pkg::vert_t  in_z;

  logic             out_valid;
  tvbb_pkg::coord_t low_corner  [tvbb_pkg::NUM_ROWS];
  tvbb_pkg::coord_t high_corner [tvbb_pkg::NUM_ROWS];
  tvbb_pkg::coord_t low_next    [tvbb_pkg::NUM_ROWS];
  tvbb_pkg::coord_t high_next   [tvbb_pkg::NUM_ROWS];

  logic             advance;
  logic             s_fire;

  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !rst && (!in_valid || advance);
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid;

  // Configuration rows; writes beyond the last row are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      rows[0] <= tvbb_pkg::ROW_X_RESET;
      rows[1] <= tvbb_pkg::ROW_Y_RESET;
      rows[2] <= tvbb_pkg::ROW_Z_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        tvbb_pkg::REG_ROW_X: rows[0] <= cfg_data;
        tvbb_pkg::REG_ROW_Y: rows[1] <= cfg_data;
        tvbb_pkg::REG_ROW_Z: rows[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_fire) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      in_first <= s_axis_tuser;
      in_x     <= s_axis_tdata[15:0];
      in_y     <= s_axis_tdata[31:16];
      in_z     <= s_axis_tdata[47:32];
    end
  end

  // Transform and fold; a corner moves on a first vertex or on strict improvement.
  always_comb begin
    tvbb_pkg::coord_t t;
    for (int i = 0; i < tvbb_pkg::NUM_ROWS; i++) begin
      t = tvbb_pkg::apply_row(rows[i], in_x, in_y, in_z);
      low_next[i]  = low_corner[i];
      high_next[i] = high_corner[i];
      if (in_first) begin
        low_next[i]  = t;
        high_next[i] = t;
      end else begin
        if (t < low_corner[i])  low_next[i]  = t;
        if (high_corner[i] < t) high_next[i] = t;
      end
    end
  end

  // Corners double as the result register: they change only when a
  // transaction moves from the input register into the output stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      for (int i = 0; i < tvbb_pkg::NUM_ROWS; i++) begin
        low_corner[i]  <= tvbb_pkg::CORNER_MAX;
        high_corner[i] <= tvbb_pkg::CORNER_MIN;
      end
    end else begin
      if (advance) begin
        out_valid <= 1'b1;
        for (int i = 0; i < tvbb_pkg::NUM_ROWS; i++) begin
          low_corner[i]  <= low_next[i];
          high_corner[i] <= high_next[i];
        end
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign m_axis_tdata = {2'b00,
                         high_corner[2], high_corner[1], high_corner[0],
                         low_corner[2],  low_corner[1],  low_corner[0]};

endmodule

// File: rtl/core/tvbb_checker.sv
// Port-level checker for the transformed-vertex bounding box, with its bind.
// Depends on tvbb_pkg and transformed_vertex_bounding_box.
`timescale 1ns / 1ps

module tvbb_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              s_axis_tvalid,
  input logic                              s_axis_tready,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [tvbb_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);

  tvbb_pkg::coord_t min_x, min_y, min_z, max_x, max_y, max_z;

  assign min_x = m_axis_tdata[20:0];
  assign min_y = m_axis_tdata[41:21];
  assign min_z = m_axis_tdata[62:42];
  assign max_x = m_axis_tdata[83:63];
  assign max_y = m_axis_tdata[104:84];
  assign max_z = m_axis_tdata[125:105];

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed or dropped while stalled");

  // Any shown box holds at least one vertex, so it is never inverted.
  a_box_order: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> min_x <= max_x && min_y <= max_y && min_z <= max_z)
    else $error("bounding box corners inverted");

  // A result appears after an empty output once its transaction passes the input and corner registers.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
    else $error("result without matching input transaction");

  // Input backpressure only when the output side is stalled; tready is low in reset.
  a_ready_cause: assert property (@(posedge clk) disable iff (rst)
    !rst && !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled while output could drain");

endmodule

bind transformed_vertex_bounding_box tvbb_checker u_tvbb_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
